[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the pulse emission scheduler.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define PES_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define PES_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/pes_pkg.sv]
// ---------------------------------------------------------------------------
// Pulse emission scheduler package
// Widths, register indexes and controller/datapath interface types.
// ---------------------------------------------------------------------------
package pes_pkg;

  localparam int SLOT_COUNT = 16;
  localparam int SLOT_IDX_W = $clog2(SLOT_COUNT);
  localparam int PHASE_W    = 24;
  localparam int SYNC_W     = 16;
  localparam int CNT_W      = 16;
  localparam int RELEASE_W  = 16;
  localparam int FADE_W     = 16;
  localparam int IDX_OUT_W  = 4;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;
  localparam int DIV_STEPS  = PHASE_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int PROD_W     = (SYNC_W - 1) + PHASE_W;
  localparam int REM_W      = SYNC_W;

  localparam logic [CFG_IDX_W-1:0] REG_PHASE_INC   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FREE_RUN    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_EN     = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_BURST_COUNT = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_REST_COUNT  = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_OVERLAP     = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_MAIN_ACTIVE = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_REST_ACTIVE = CFG_IDX_W'(7);

  typedef logic [SLOT_COUNT-1:0] slot_vec_t;

  typedef struct packed {
    logic eval;
    logic div_step;
    logic commit;
  } pes_cmd_t;

  typedef struct packed {
    logic need_div;
  } pes_sts_t;

endpackage

[rtl/pes_ctrl.sv]
// ---------------------------------------------------------------------------
// Pulse emission scheduler controller
// Sequences evaluate, serial divide and commit; owns the result handshake.
// ---------------------------------------------------------------------------
module pes_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output pes_pkg::pes_cmd_t cmd,
  input  pes_pkg::pes_sts_t sts
);
  import pes_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_DIV    = 3'b010,
    S_COMMIT = 3'b100
  } state_t;

  state_t               state_r, state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.eval  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = sts.need_div ? S_DIV : S_COMMIT;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (out_free) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[rtl/pes_datapath.sv]
// ---------------------------------------------------------------------------
// Pulse emission scheduler datapath
// Config registers, phase and sync logic, serial divider, mask and slots.
// ---------------------------------------------------------------------------
module pes_datapath (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [pes_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [pes_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic signed [pes_pkg::SYNC_W-1:0]     in_sync_sample,
  input  logic [pes_pkg::RELEASE_W-1:0]         in_released_slots,
  input  pes_pkg::pes_cmd_t                     cmd,
  output pes_pkg::pes_sts_t                     sts,
  output logic                                  out_emitted,
  output logic                                  out_dropped,
  output logic [pes_pkg::IDX_OUT_W-1:0]         out_slot_index,
  output logic                                  out_rest_pulse,
  output logic [pes_pkg::PHASE_W-1:0]           out_start_phase,
  output logic [pes_pkg::FADE_W-1:0]            out_fade_mask
);
  import pes_pkg::*;

  // configuration
  logic [PHASE_W-1:0] phase_inc_r;
  logic               free_run_r, sync_en_r, overlap_r, main_active_r, rest_active_r;
  logic [CNT_W-1:0]   burst_count_r, rest_count_r;

  // state
  logic [PHASE_W-1:0]       emit_phase_r, emit_phase_nxt;
  logic signed [SYNC_W-1:0] last_sync_r;
  logic [CNT_W-1:0]         mask_count_r, mask_count_nxt;
  logic                     in_rest_r, in_rest_nxt;
  slot_vec_t                slot_busy_r, slot_busy_nxt;
  slot_vec_t                slot_class_r, slot_class_nxt;

  // per-item work registers
  logic                 emit_r, div_used_r;
  logic [REM_W-1:0]     rem_r, rem_nxt;
  logic [PHASE_W-1:0]   quo_r, quo_nxt;
  logic [SYNC_W-1:0]    den_r;

  // result registers
  logic                 emitted_r, dropped_r, rest_pulse_r;
  logic [IDX_OUT_W-1:0] slot_index_r;
  logic [PHASE_W-1:0]   start_phase_r;
  logic [FADE_W-1:0]    fade_mask_r;

  // evaluate
  logic [PHASE_W:0]     phase_sum;
  logic                 fr_emit, sync_ok, neg_cross, zero_cross;
  logic [PHASE_W-1:0]   phase_eval;
  logic [PROD_W-1:0]    prod;
  logic [SYNC_W:0]      den_full;
  slot_vec_t            rel_slots;

  assign phase_sum  = {1'b0, emit_phase_r} + {1'b0, phase_inc_r};
  assign fr_emit    = free_run_r && phase_sum[PHASE_W];
  assign sync_ok    = sync_en_r && !in_sync_sample[SYNC_W-1];
  assign neg_cross  = sync_ok && last_sync_r[SYNC_W-1];
  assign zero_cross = sync_ok && !last_sync_r[SYNC_W-1] && (last_sync_r != '0)
                      && (in_sync_sample == '0);
  assign phase_eval = zero_cross ? '0 :
                      (free_run_r ? phase_sum[PHASE_W-1:0] : emit_phase_r);
  assign prod       = PROD_W'(in_sync_sample[SYNC_W-2:0]) * PROD_W'(phase_inc_r);
  assign den_full   = {in_sync_sample[SYNC_W-1], in_sync_sample}
                      - {last_sync_r[SYNC_W-1], last_sync_r};
  assign rel_slots  = SLOT_COUNT'(in_released_slots);
  assign sts.need_div = neg_cross;

  // divide step
  logic [REM_W:0] trial;
  assign trial = {rem_r, quo_r[PHASE_W-1]} - {1'b0, den_r};

  // commit
  logic [PHASE_W-1:0]    phase_c;
  logic [CNT_W-1:0]      mask_max;
  logic [CNT_W:0]        cnt_inc;
  logic                  cls, wrap, active, any_free, do_emit, do_drop;
  slot_vec_t             free_slots, new_bit, same_cls, fade;
  logic [SLOT_IDX_W-1:0] free_idx;

  assign phase_c    = div_used_r ? quo_r : emit_phase_r;
  assign mask_max   = in_rest_r ? rest_count_r : burst_count_r;
  assign cls        = in_rest_r ^ (mask_max == '0);
  assign cnt_inc    = {1'b0, mask_count_r} + (CNT_W + 1)'(1);
  assign wrap       = (cnt_inc >= {1'b0, mask_max});
  assign active     = cls ? rest_active_r : main_active_r;
  assign free_slots = ~slot_busy_r;
  assign any_free   = |free_slots;
  assign do_emit    = emit_r && active && any_free;
  assign do_drop    = emit_r && active && !any_free;
  assign same_cls   = cls ? slot_class_r : ~slot_class_r;

  always_comb begin
    free_idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (free_slots[i]) begin
        free_idx = SLOT_IDX_W'(i);
      end
    end
  end

  assign new_bit = slot_vec_t'(1) << free_idx;
  assign fade    = overlap_r ? '0 : (slot_busy_r & same_cls & ~new_bit);

  always_comb begin
    emit_phase_nxt = emit_phase_r;
    mask_count_nxt = mask_count_r;
    in_rest_nxt    = in_rest_r;
    slot_busy_nxt  = slot_busy_r;
    slot_class_nxt = slot_class_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    if (cfg_we && (cfg_index == REG_FREE_RUN) && (cfg_data[0] != free_run_r)) begin
      emit_phase_nxt = '0;
    end
    if (cmd.eval) begin
      emit_phase_nxt = phase_eval;
      slot_busy_nxt  = slot_busy_r & ~rel_slots;
      rem_nxt        = REM_W'(prod[PROD_W-1:PHASE_W]);
      quo_nxt        = prod[PHASE_W-1:0];
    end
    if (cmd.div_step) begin
      if (!trial[REM_W]) begin
        rem_nxt = trial[REM_W-1:0];
      end else begin
        rem_nxt = {rem_r[REM_W-2:0], quo_r[PHASE_W-1]};
      end
      quo_nxt = {quo_r[PHASE_W-2:0], !trial[REM_W]};
    end
    if (cmd.commit) begin
      emit_phase_nxt = phase_c;
      if (emit_r) begin
        mask_count_nxt = wrap ? '0 : cnt_inc[CNT_W-1:0];
        in_rest_nxt    = cls ^ wrap;
      end
      if (do_emit) begin
        slot_busy_nxt  = slot_busy_r | new_bit;
        slot_class_nxt = cls ? (slot_class_r | new_bit) : (slot_class_r & ~new_bit);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_inc_r   <= '0;
      free_run_r    <= 1'b1;
      sync_en_r     <= 1'b0;
      burst_count_r <= CNT_W'(1);
      rest_count_r  <= '0;
      overlap_r     <= 1'b0;
      main_active_r <= 1'b1;
      rest_active_r <= 1'b1;
      emit_phase_r  <= '0;
      last_sync_r   <= '0;
      mask_count_r  <= '0;
      in_rest_r     <= 1'b0;
      slot_busy_r   <= '0;
      slot_class_r  <= '0;
      emit_r        <= 1'b0;
      div_used_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_PHASE_INC:   phase_inc_r   <= cfg_data[PHASE_W-1:0];
          REG_FREE_RUN:    free_run_r    <= cfg_data[0];
          REG_SYNC_EN:     sync_en_r     <= cfg_data[0];
          REG_BURST_COUNT: burst_count_r <= cfg_data[CNT_W-1:0];
          REG_REST_COUNT:  rest_count_r  <= cfg_data[CNT_W-1:0];
          REG_OVERLAP:     overlap_r     <= cfg_data[0];
          REG_MAIN_ACTIVE: main_active_r <= cfg_data[0];
          REG_REST_ACTIVE: rest_active_r <= cfg_data[0];
          default: begin
          end
        endcase
      end
      emit_phase_r <= emit_phase_nxt;
      mask_count_r <= mask_count_nxt;
      in_rest_r    <= in_rest_nxt;
      slot_busy_r  <= slot_busy_nxt;
      slot_class_r <= slot_class_nxt;
      if (cmd.eval) begin
        last_sync_r <= in_sync_sample;
        emit_r      <= fr_emit || neg_cross || zero_cross;
        div_used_r  <= neg_cross;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (cmd.eval) begin
      den_r <= den_full[SYNC_W-1:0];
    end
    if (cmd.commit) begin
      emitted_r     <= do_emit;
      dropped_r     <= do_drop;
      slot_index_r  <= do_emit ? IDX_OUT_W'(free_idx) : '0;
      rest_pulse_r  <= (do_emit || do_drop) ? cls : 1'b0;
      start_phase_r <= (do_emit || do_drop) ? phase_c : '0;
      fade_mask_r   <= do_emit ? FADE_W'(fade) : '0;
    end
  end

  assign out_emitted     = emitted_r;
  assign out_dropped     = dropped_r;
  assign out_slot_index  = slot_index_r;
  assign out_rest_pulse  = rest_pulse_r;
  assign out_start_phase = start_phase_r;
  assign out_fade_mask   = fade_mask_r;

endmodule

[rtl/pulse_emission_scheduler.sv]
// ---------------------------------------------------------------------------
// Pulse emission scheduler
// Per-tick phase, sync and burst-mask emission with lowest-free slot
// allocation and same-class fade flags.
// ---------------------------------------------------------------------------
//  channel | direction | handshake            | word
//  in_     | input     | in_valid/in_ready    | sync_sample, released_slots
//  out_    | output    | out_valid/out_ready  | emitted .. fade_mask
//  cfg_    | input     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
//  An input word is evaluated on accept and written to the result register at
//  commit; a sync crossing from a negative sample first runs the 24-step serial
//  divide between the two.
//  One word is in work at a time; the next is accepted after commit, while
//  the previous result may still wait in the output register.
//  Commit stalls while the output register holds an untaken result.
//  Reset is synchronous (rst_n low) and needs no clearing pass; cfg_ready is
//  always high.
// ---------------------------------------------------------------------------
module pulse_emission_scheduler (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [pes_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [pes_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [pes_pkg::SYNC_W-1:0]     in_sync_sample,
  input  logic [pes_pkg::RELEASE_W-1:0]         in_released_slots,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_emitted,
  output logic                                  out_dropped,
  output logic [pes_pkg::IDX_OUT_W-1:0]         out_slot_index,
  output logic                                  out_rest_pulse,
  output logic [pes_pkg::PHASE_W-1:0]           out_start_phase,
  output logic [pes_pkg::FADE_W-1:0]            out_fade_mask
);
  import pes_pkg::*;

  pes_cmd_t cmd;
  pes_sts_t sts;

  assign cfg_ready = 1'b1;

  pes_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  pes_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_sync_sample    (in_sync_sample),
    .in_released_slots (in_released_slots),
    .cmd               (cmd),
    .sts               (sts),
    .out_emitted       (out_emitted),
    .out_dropped       (out_dropped),
    .out_slot_index    (out_slot_index),
    .out_rest_pulse    (out_rest_pulse),
    .out_start_phase   (out_start_phase),
    .out_fade_mask     (out_fade_mask)
  );

endmodule

[rtl/pes_checker.sv]
// ---------------------------------------------------------------------------
// Pulse emission scheduler checker
// Port-level properties of the result channel, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pes_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic                                  out_emitted,
  input logic                                  out_dropped,
  input logic [pes_pkg::IDX_OUT_W-1:0]         out_slot_index,
  input logic                                  out_rest_pulse,
  input logic [pes_pkg::PHASE_W-1:0]           out_start_phase,
  input logic [pes_pkg::FADE_W-1:0]            out_fade_mask
);

  `PES_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_start_phase) && $stable(out_fade_mask), "result word changed while stalled")
  `PES_ASSERT(a_emit_xor_drop, clk, rst_n, out_valid |-> !(out_emitted && out_dropped), "emitted and dropped both set")
  `PES_ASSERT(a_no_alloc_zero, clk, rst_n, out_valid && !out_emitted |-> (out_slot_index == '0) && (out_fade_mask == '0), "slot fields set without allocation")
  `PES_ASSERT(a_idle_zero, clk, rst_n, out_valid && !out_emitted && !out_dropped |-> (out_start_phase == '0) && !out_rest_pulse, "fields set without emission")
  `PES_ASSERT_ALWAYS(a_reset_clear, clk, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind pulse_emission_scheduler pes_checker u_pes_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_emitted     (out_emitted),
  .out_dropped     (out_dropped),
  .out_slot_index  (out_slot_index),
  .out_rest_pulse  (out_rest_pulse),
  .out_start_phase (out_start_phase),
  .out_fade_mask   (out_fade_mask)
);
